// File: design/ryuv_pkg.sv
// shared types, constants and arithmetic helpers of the rgb to yuv 4:2:0 converter
package ryuv_pkg;

  localparam int unsigned MaxWidth    = 4096;
  localparam int unsigned MaxHeight   = 4096;
  localparam int unsigned SizeW       = 13;
  localparam int unsigned ColW        = $clog2(MaxWidth);
  localparam int unsigned RowW        = $clog2(MaxHeight);
  localparam int unsigned LumaIdxW    = 24;
  localparam int unsigned ChromaIdxW  = 22;
  localparam int unsigned PixW        = 8;
  localparam int unsigned SumW        = 27;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = SizeW;

  localparam logic [CfgIdxW-1:0] RegImageWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 1'b1;

  localparam logic [SizeW-1:0] ResetWidth  = 13'd640;
  localparam logic [SizeW-1:0] ResetHeight = 13'd480;
  localparam logic [SizeW-1:0] MaxWidthV   = SizeW'(MaxWidth);
  localparam logic [SizeW-1:0] MaxHeightV  = SizeW'(MaxHeight);

  // weights in units of 1e-5
  localparam logic signed [SumW-1:0] KyR = 27'sd29900;
  localparam logic signed [SumW-1:0] KyG = 27'sd58700;
  localparam logic signed [SumW-1:0] KyB = 27'sd11400;
  localparam logic signed [SumW-1:0] KuR = 27'sd14713;
  localparam logic signed [SumW-1:0] KuG = 27'sd28886;
  localparam logic signed [SumW-1:0] KuB = 27'sd43600;
  localparam logic signed [SumW-1:0] KvR = 27'sd61500;
  localparam logic signed [SumW-1:0] KvG = 27'sd51499;
  localparam logic signed [SumW-1:0] KvB = 27'sd10001;
  localparam logic signed [SumW-1:0] KBias = 27'sd12800000;

  // floor(s / 100000) by reciprocal, exact below the saturation point
  localparam int unsigned RecipW     = 25;
  localparam int unsigned RecipShift = 41;
  localparam logic [RecipW-1:0] FxRecip = 25'd21990233;
  localparam logic signed [SumW-1:0] FxSat = 27'sd25600000;

  typedef struct packed {
    logic [LumaIdxW-1:0]   luma_index;
    logic                  chroma_valid;
    logic [ChromaIdxW-1:0] chroma_index;
    logic                  frame_end;
  } pos_t;

  typedef struct packed {
    logic signed [SumW-1:0] sy;
    logic signed [SumW-1:0] su;
    logic signed [SumW-1:0] sv;
  } sums_t;

  function automatic logic [PixW-1:0] to_byte(input logic signed [SumW-1:0] s);
    logic [SumW+RecipW-2:0] prod;
    logic [PixW-1:0]        res;
    prod = '0;
    if (s < 0) begin
      res = '0;
    end else if (s >= FxSat) begin
      res = '1;
    end else begin
      prod = {{RecipW{1'b0}}, s[SumW-2:0]} * {{(SumW-1){1'b0}}, FxRecip};
      res  = prod[RecipShift+PixW-1:RecipShift];
    end
    return res;
  endfunction

endpackage

// File: design/ryuv_position.sv
// frame size registers, raster counters and per-pixel plane indexes
module ryuv_position (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ryuv_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ryuv_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                           advance_i,
  output ryuv_pkg::pos_t                 pos_o
);
  import ryuv_pkg::*;

  logic [SizeW-1:0]      width_q, width_d, height_q, height_d;
  logic [ColW-1:0]       col_q, col_d;
  logic [RowW-1:0]       row_q, row_d;
  logic [LumaIdxW-1:0]   luma_idx_q, luma_idx_d;
  logic [ChromaIdxW-1:0] chroma_idx_q, chroma_idx_d;
  logic [SizeW-1:0]      w_eff, h_eff, w_last, h_last;
  logic                  col_end, row_end, cv, restart;

  always_comb begin
    if (width_q == '0) begin
      w_eff = SizeW'(1);
    end else if (width_q > MaxWidthV) begin
      w_eff = MaxWidthV;
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = SizeW'(1);
    end else if (height_q > MaxHeightV) begin
      h_eff = MaxHeightV;
    end else begin
      h_eff = height_q;
    end
  end

  assign w_last  = w_eff - SizeW'(1);
  assign h_last  = h_eff - SizeW'(1);
  assign col_end = ({{(SizeW-ColW){1'b0}}, col_q} == w_last);
  assign row_end = ({{(SizeW-RowW){1'b0}}, row_q} == h_last);
  assign cv      = !col_q[0] && !row_q[0] &&
                   ({{(SizeW-ColW+1){1'b0}}, col_q[ColW-1:1]} < {1'b0, w_eff[SizeW-1:1]}) &&
                   ({{(SizeW-RowW+1){1'b0}}, row_q[RowW-1:1]} < {1'b0, h_eff[SizeW-1:1]});

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    restart  = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegImageWidth: begin
          width_d = cfg_wdata_i;
          restart = 1'b1;
        end
        RegImageHeight: begin
          height_d = cfg_wdata_i;
          restart = 1'b1;
        end
        default: restart = 1'b0;
      endcase
    end
  end

  always_comb begin
    col_d        = col_q;
    row_d        = row_q;
    luma_idx_d   = luma_idx_q;
    chroma_idx_d = chroma_idx_q;
    if (restart) begin
      col_d        = '0;
      row_d        = '0;
      luma_idx_d   = '0;
      chroma_idx_d = '0;
    end else if (advance_i) begin
      if (col_end && row_end) begin
        col_d        = '0;
        row_d        = '0;
        luma_idx_d   = '0;
        chroma_idx_d = '0;
      end else begin
        luma_idx_d = luma_idx_q + LumaIdxW'(1);
        if (cv) begin
          chroma_idx_d = chroma_idx_q + ChromaIdxW'(1);
        end
        if (col_end) begin
          col_d = '0;
          row_d = row_q + RowW'(1);
        end else begin
          col_d = col_q + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= ResetWidth;
      height_q     <= ResetHeight;
      col_q        <= '0;
      row_q        <= '0;
      luma_idx_q   <= '0;
      chroma_idx_q <= '0;
    end else begin
      width_q      <= width_d;
      height_q     <= height_d;
      col_q        <= col_d;
      row_q        <= row_d;
      luma_idx_q   <= luma_idx_d;
      chroma_idx_q <= chroma_idx_d;
    end
  end

  assign pos_o.luma_index   = luma_idx_q;
  assign pos_o.chroma_valid = cv;
  assign pos_o.chroma_index = cv ? chroma_idx_q : '0;
  assign pos_o.frame_end    = col_end && row_end;

endmodule

// File: design/ryuv_color.sv
// pixel datapath: input register, weighted sums register, clamped result register
module ryuv_color (
  input  logic                        clk_i,
  input  logic                        load0_i,
  input  logic                        load1_i,
  input  logic                        load2_i,
  input  logic [ryuv_pkg::PixW-1:0]   red_i,
  input  logic [ryuv_pkg::PixW-1:0]   green_i,
  input  logic [ryuv_pkg::PixW-1:0]   blue_i,
  input  ryuv_pkg::pos_t              pos_i,
  output logic [ryuv_pkg::PixW-1:0]   luma_o,
  output logic [ryuv_pkg::PixW-1:0]   chroma_u_o,
  output logic [ryuv_pkg::PixW-1:0]   chroma_v_o,
  output ryuv_pkg::pos_t              pos_o
);
  import ryuv_pkg::*;

  logic [PixW-1:0] red_q, green_q, blue_q;
  pos_t            pos0_q, pos1_q, pos2_q;
  sums_t           sums_d, sums_q;
  logic [PixW-1:0] luma_d, luma_q, u_d, u_q, v_d, v_q;
  logic signed [SumW-1:0] r_s, g_s, b_s;

  assign r_s = $signed({{(SumW-PixW){1'b0}}, red_q});
  assign g_s = $signed({{(SumW-PixW){1'b0}}, green_q});
  assign b_s = $signed({{(SumW-PixW){1'b0}}, blue_q});

  always_comb begin
    sums_d.sy = KyR * r_s + KyG * g_s + KyB * b_s;
    sums_d.su = KBias - KuR * r_s - KuG * g_s + KuB * b_s;
    sums_d.sv = KBias + KvR * r_s - KvG * g_s - KvB * b_s;
  end

  always_comb begin
    luma_d = to_byte(sums_q.sy);
    u_d    = pos1_q.chroma_valid ? to_byte(sums_q.su) : '0;
    v_d    = pos1_q.chroma_valid ? to_byte(sums_q.sv) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (load0_i) begin
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
      pos0_q  <= pos_i;
    end
    if (load1_i) begin
      sums_q <= sums_d;
      pos1_q <= pos0_q;
    end
    if (load2_i) begin
      luma_q <= luma_d;
      u_q    <= u_d;
      v_q    <= v_d;
      pos2_q <= pos1_q;
    end
  end

  assign luma_o     = luma_q;
  assign chroma_u_o = u_q;
  assign chroma_v_o = v_q;
  assign pos_o      = pos2_q;

endmodule

// File: design/rgb_to_yuv420p_converter.sv
// top level of the rgb888 to yuv 4:2:0 planar converter
//
// input channel: one rgb888 pixel per request, frame in raster order, taken
// at a clock edge where in_valid_i is high and in_stall_o is low.
// output channel: one result per pixel in the same order: luma and its plane
// index, top-left chroma pick with its plane index when chroma_valid_o is 1
// (otherwise u, v and chroma index are 0), and frame_end_o on the last pixel.
// taken at an edge where out_valid_o is high and out_stall_i is low.
// from input request to output valid a pixel passes the input
// register, the weighted sums register and the clamped result register.
// throughput is one pixel per cycle while out_stall_i is low; each stage holds one pixel and the
// three stages absorb a stall, so in_stall_o rises only once all are full.
// a stalled result holds steady on the output until taken.
// reset clears the pipeline and raster counters and sets the frame to
// 640 x 480. a write to either size register restarts the frame at pixel 0;
// the user must make writes only while the pipeline is empty; the block does not enforce it.
module rgb_to_yuv420p_converter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ryuv_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [ryuv_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        red_i,
  input  logic [7:0]                        green_i,
  input  logic [7:0]                        blue_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [7:0]                        luma_o,
  output logic [ryuv_pkg::LumaIdxW-1:0]    luma_index_o,
  output logic                              chroma_valid_o,
  output logic [7:0]                        chroma_u_o,
  output logic [7:0]                        chroma_v_o,
  output logic [ryuv_pkg::ChromaIdxW-1:0]  chroma_index_o,
  output logic                              frame_end_o
);
  import ryuv_pkg::*;

  logic v0_q, v0_d, v1_q, v1_d, v2_q, v2_d;
  logic ready0, ready1, ready2;
  logic load0, load1, load2;
  pos_t pos_in, pos_out;

  assign ready2 = !v2_q || !out_stall_i;
  assign ready1 = !v1_q || ready2;
  assign ready0 = !v0_q || ready1;
  assign load0  = in_valid_i && ready0;
  assign load1  = v0_q && ready1;
  assign load2  = v1_q && ready2;

  assign v0_d = load0 || (v0_q && !ready1);
  assign v1_d = load1 || (v1_q && !ready2);
  assign v2_d = load2 || (v2_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  ryuv_position u_position (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (load0),
    .pos_o       (pos_in)
  );

  ryuv_color u_color (
    .clk_i      (clk_i),
    .load0_i    (load0),
    .load1_i    (load1),
    .load2_i    (load2),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .pos_i      (pos_in),
    .luma_o     (luma_o),
    .chroma_u_o (chroma_u_o),
    .chroma_v_o (chroma_v_o),
    .pos_o      (pos_out)
  );

  assign in_stall_o     = !ready0;
  assign out_valid_o    = v2_q;
  assign luma_index_o   = pos_out.luma_index;
  assign chroma_valid_o = pos_out.chroma_valid;
  assign chroma_index_o = pos_out.chroma_index;
  assign frame_end_o    = pos_out.frame_end;

endmodule
